// File: rtl/qdp_pkg.sv
// Shared types, constants and rounding function for the Q16.16 dot product block.
package qdp_pkg;

   localparam int ValueWidth   = 32;
   localparam int ProductWidth = 2 * ValueWidth;
   localparam int FracBits     = 16;
   localparam int KeepWidth    = ValueWidth + FracBits;

   localparam logic [KeepWidth-1:0] RoundHalf = KeepWidth'(16'h8000);

   typedef logic signed [ValueWidth-1:0]   value_type;
   typedef logic signed [ProductWidth-1:0] product_type;

   typedef struct packed {
      logic        valid;
      logic        last;
      product_type product;
   } qdp_prod_type;

   // Rounds a full Q32.32 product to Q16.16, keeping product bits 47:16, so the integer part wraps.
   function automatic value_type qdp_round(product_type p);
      logic [KeepWidth-1:0] adjusted;
      adjusted = p[KeepWidth-1:0] - RoundHalf - KeepWidth'(p[ProductWidth-1]);
      return value_type'(adjusted[KeepWidth-1:FracBits] + ValueWidth'(1));
   endfunction

endpackage

// File: rtl/qdp_if.sv
// Stream interfaces for element pair beats and dot product result beats.
interface qdp_req_if import qdp_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type a_value;
   value_type b_value;
   logic      last;

   modport source (output valid, output a_value, output b_value, output last, input ready);
   modport sink   (input valid, input a_value, input b_value, input last, output ready);
endinterface

interface qdp_rsp_if import qdp_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type dot_sum;

   modport source (output valid, output dot_sum, input ready);
   modport sink   (input valid, input dot_sum, output ready);
endinterface

// File: rtl/qdp_mult.sv
// Input register and registered 32 by 32 signed multiplier stage.
module qdp_mult import qdp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   qdp_req_if.sink      req_bus,
   input  logic         advance,
   output qdp_prod_type prod
);

   logic         in_valid_ff;
   logic         in_valid_in;
   logic         in_last_ff;
   value_type    in_a_ff;
   value_type    in_b_ff;
   qdp_prod_type prod_ff;
   qdp_prod_type prod_in;

   assign req_bus.ready = advance;
   assign in_valid_in   = req_bus.valid;

   always_comb begin
      prod_in.valid   = in_valid_ff;
      prod_in.last    = in_last_ff;
      prod_in.product = in_a_ff * in_b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         prod_ff.valid <= 1'b0;
      end else if (advance) begin
         in_valid_ff     <= in_valid_in;
         in_last_ff      <= req_bus.last;
         in_a_ff         <= req_bus.a_value;
         in_b_ff         <= req_bus.b_value;
         prod_ff.valid   <= prod_in.valid;
         prod_ff.last    <= prod_in.last;
         prod_ff.product <= prod_in.product;
      end
   end

   assign prod = prod_ff;

endmodule

// File: rtl/qdp_accum.sv
// Rounding, wrapping accumulator and result register.
module qdp_accum import qdp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  qdp_prod_type prod,
   output logic         advance,
   qdp_rsp_if.source    rsp_bus
);

   value_type acc_ff;
   value_type acc_in;
   value_type sum_in;
   logic      out_valid_ff;
   logic      out_valid_in;
   value_type out_sum_ff;
   logic      take;

   assign advance = !(prod.valid && prod.last && out_valid_ff && !rsp_bus.ready);
   assign take    = advance && prod.valid;
   assign sum_in  = acc_ff + qdp_round(prod.product);

   always_comb begin
      acc_in       = acc_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      if (take) begin
         if (prod.last) begin
            acc_in       = '0;
            out_valid_in = 1'b1;
         end else begin
            acc_in = sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && prod.last) begin
         out_sum_ff <= sum_in;
      end
   end

   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.dot_sum = out_sum_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !advance |-> (out_valid_ff && !rsp_bus.ready && prod.valid && prod.last))
      else $error("Pipeline stalled while the result register could take a beat.");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (take && prod.last) |=> (acc_ff == '0 && out_valid_ff))
      else $error("Accumulator not cleared or result not posted after a last pair.");

   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      (!(take && prod.last) && (!out_valid_ff || rsp_bus.ready)) |=> !out_valid_ff)
      else $error("Result beat appeared without a last pair.");

   a_stall_holds_sum: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(acc_ff))
      else $error("Accumulator changed during a stall.");

endmodule

// File: rtl/q16_fixed_point_dot_product.sv
// Top level of the streaming Q16.16 fixed-point dot product block.
// Accepts one element pair beat per cycle while not stalled. Each pair is registered,
// multiplied exactly to 64 bits in a registered multiplier stage, then rounded to Q16.16
// and added into a 32-bit wrapping accumulator. On the pair marked last, the sum goes to
// the result register and the accumulator clears, so the next vector may follow with no
// gap. The last pair passes the input register and the product register before its sum
// is registered as the result beat. Input stalls only when a last pair reaches the
// accumulator while the previous result beat has not yet been taken.
module q16_fixed_point_dot_product import qdp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   qdp_req_if.sink   req_bus,
   qdp_rsp_if.source rsp_bus
);

   qdp_prod_type prod;
   logic         advance;

   qdp_mult u_mult (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .advance (advance),
      .prod    (prod)
   );

   qdp_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .prod    (prod),
      .advance (advance),
      .rsp_bus (rsp_bus)
   );

endmodule

// File: bench/qdp_sum_checker.sv
`timescale 1ns / 1ps
// Checker that predicts each vector's dot product sum from pair beats and compares result beats.
module qdp_sum_checker import qdp_pkg::*; (
   input  logic clock,
   input  logic reset,
   qdp_req_if   req_bus,
   qdp_rsp_if   rsp_bus,
   output int   mismatch_count,
   output int   sums_pending,
   output int   sums_checked
);

   value_type expected_sums[$];
   value_type partial_sum;
   value_type oldest_sum;

   function automatic value_type q16_product(value_type a, value_type b);
      logic signed [63:0] wide_a;
      logic signed [63:0] wide_b;
      logic signed [63:0] full;
      logic signed [63:0] shifted;
      wide_a = a;
      wide_b = b;
      full = wide_a * wide_b;
      full = full - 64'sd32768 - ((full < 0) ? 64'sd1 : 64'sd0);
      shifted = full >>> 16;
      return value_type'(shifted[31:0] + 32'd1);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         partial_sum = '0;
         expected_sums.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_sums.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Unexpected result beat: dot_sum %0d (0x%08h)",
                           rsp_bus.dot_sum, rsp_bus.dot_sum);
               end
            end else begin
               oldest_sum = expected_sums.pop_front();
               sums_checked++;
               if (rsp_bus.dot_sum !== oldest_sum) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("dot_sum mismatch: expected 0x%08h, got 0x%08h",
                              oldest_sum, rsp_bus.dot_sum);
                  end
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            partial_sum = partial_sum + q16_product(req_bus.a_value, req_bus.b_value);
            if (req_bus.last) begin
               expected_sums.push_back(partial_sum);
               partial_sum = '0;
            end
         end
      end
      sums_pending = expected_sums.size();
   end

endmodule

// File: bench/q16_fixed_point_dot_product_tb.sv
`timescale 1ns / 1ps
// Testbench top that streams element pair beats into the dot product block and gives the verdict.
module q16_fixed_point_dot_product_tb;
   import qdp_pkg::*;

   localparam int CycleLimit    = 400000;
   localparam int PairsPerPhase = 335;

   logic clock = 1'b0;
   logic reset = 1'b1;

   qdp_req_if req_bus();
   qdp_rsp_if rsp_bus();

   int mismatch_count;
   int sums_pending;
   int sums_checked;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int pairs_sent     = 0;
   int vectors_sent   = 0;
   int cycle_count    = 0;

   q16_fixed_point_dot_product i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   qdp_sum_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .mismatch_count (mismatch_count),
      .sums_pending   (sums_pending),
      .sums_checked   (sums_checked)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Run stopped after %0d cycles with %0d sums outstanding.",
                  cycle_count, sums_pending);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic value_type random_value();
      case ($urandom_range(0, 5))
         0, 1:    return value_type'($urandom);
         2:       return value_type'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
         3:       return value_type'($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
         4:       return value_type'(32'h7FFF_FFF0 + $urandom_range(0, 31));
         default: return value_type'($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
      endcase
   endfunction

   task automatic send_pair(input value_type a, input value_type b, input logic is_last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.a_value <= a;
      req_bus.b_value <= b;
      req_bus.last    <= is_last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pairs_sent++;
      if (is_last) vectors_sent++;
   endtask

   task automatic send_random_vector();
      int length;
      length = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int i = 0; i < length; i++) begin
         send_pair(random_value(), random_value(), i == length - 1);
      end
   endtask

   task automatic wait_for_sums();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sums_pending != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic run_random_phase(input int idle_pct, input int stall_pct);
      int phase_start;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      phase_start    = pairs_sent;
      while (pairs_sent - phase_start < PairsPerPhase) send_random_vector();
      wait_for_sums();
   endtask

   initial begin
      req_bus.valid   = 1'b0;
      req_bus.a_value = '0;
      req_bus.b_value = '0;
      req_bus.last    = 1'b0;
      rsp_bus.ready   = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
      send_pair(32'sh8000_0000, 32'sh8000_0000, 1'b1);
      send_pair(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
      send_pair(32'sh0000_0000, 32'sh0000_0000, 1'b1);
      send_pair(32'sh0000_0001, 32'sh0000_0001, 1'b1);
      send_pair(-32'sh0000_0001, 32'sh0000_0001, 1'b1);
      send_pair(32'sh0000_8000, 32'sh0000_0001, 1'b1);
      send_pair(-32'sh0000_8000, 32'sh0000_0001, 1'b1);
      send_pair(32'sh0001_0000, 32'sh0001_0000, 1'b1);
      for (int i = 0; i < 4; i++) send_pair(32'sh7FFF_0000, 32'sh0001_0000, i == 3);
      for (int i = 0; i < 3; i++) send_pair(32'sh8000_0000, 32'sh0001_0000, i == 2);
      send_pair(32'sh0003_0000, 32'sh0002_0000, 1'b0);
      send_pair(-32'sh0001_0000, 32'sh0005_0000, 1'b0);
      send_pair(32'sh0000_4000, 32'sh0000_4000, 1'b1);
      wait_for_sums();

      run_random_phase(0, 0);
      run_random_phase(80, 0);
      run_random_phase(0, 80);
      run_random_phase(31, 31);
      recv_stall_pct = 0;
      repeat (10) @(posedge clock);

      $display("Streamed %0d element pairs in %0d vectors under four pacing phases.",
               pairs_sent, vectors_sent);
      $display("Compared %0d dot product sums; %0d mismatches.", sums_checked, mismatch_count);
      if (mismatch_count == 0 && sums_pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
